// ===== hw/rtl/euler_xyz_vector_rotation_core_defines.svh =====
// Assertion macros for the checker file of the rotation core.
`ifndef EULER_XYZ_VECTOR_ROTATION_CORE_DEFINES_SVH
`define EULER_XYZ_VECTOR_ROTATION_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define EXVR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define EXVR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/exvr_pkg.sv =====
// Package: widths, constant tables, payload types and arithmetic helpers.
`timescale 1ns / 1ps
package exvr_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int MAX_STEPS    = 32;
    localparam int N_STEPS      = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

    localparam int IN_W = 32;
    localparam int Z_W  = 34;
    localparam int V_W  = 38;
    localparam int P_W  = 70;

    localparam logic signed [Z_W-1:0] GAIN    = 34'sd652032874;
    localparam logic [19:0]           RECIP45 = 20'((2**25 + 44) / 45);

    localparam logic [31:0] ATAN_TURN [MAX_STEPS+1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000, 32'h00000000
    };

    typedef logic [31:0] t_qtab [64];
    typedef logic [5:0]  t_rtab [64];

    function automatic t_qtab f_qtab();
        t_qtab q;
        longint unsigned num;
        for (int k = 0; k < 64; k++) begin
            num  = longint'(k) << 32;
            q[k] = (k < 45) ? 32'(num / 45) : 32'd0;
        end
        return q;
    endfunction

    function automatic t_rtab f_rtab();
        t_rtab r;
        longint unsigned num;
        for (int k = 0; k < 64; k++) begin
            num  = longint'(k) << 32;
            r[k] = (k < 45) ? 6'(num % 45) : 6'd0;
        end
        return r;
    endfunction

    localparam t_qtab QTAB = f_qtab();
    localparam t_rtab RTAB = f_rtab();

    typedef logic signed [IN_W-1:0] t_word;
    typedef logic signed [V_W-1:0]  t_val;
    typedef logic signed [P_W-1:0]  t_prod;

    typedef struct packed {
        t_word x;
        t_word y;
        t_word z;
    } t_vec;

    typedef struct packed {
        logic signed [Z_W-1:0] x;
        logic signed [Z_W-1:0] y;
        logic signed [Z_W-1:0] z;
        logic                  neg;
    } t_lane;

    typedef struct packed {
        t_vec        vec;
        t_lane [2:0] lane;
    } t_crd;

    typedef struct packed {
        t_word c;
        t_word s;
    } t_sc;

    typedef struct packed {
        t_vec      vec;
        t_sc [2:0] sc;
    } t_trig;

    function automatic t_val f_rnd(input t_prod p);
        t_prod s;
        s = p + (t_prod'(1) <<< 29);
        return s[V_W+29:30];
    endfunction

    function automatic t_word f_sat(input t_val v);
        t_val r;
        r = v;
        if (v > t_val'(64'sd2147483647)) begin
            r = t_val'(64'sd2147483647);
        end
        if (v < t_val'(-64'sd2147483648)) begin
            r = t_val'(-64'sd2147483648);
        end
        return r[IN_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/exvr_in_if.sv =====
// Input channel: vector and angle word with valid/ready.
`timescale 1ns / 1ps
interface exvr_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] angle_x;
    logic signed [31:0] angle_y;
    logic signed [31:0] angle_z;

    modport source (output valid, vec_x, vec_y, vec_z, angle_x, angle_y, angle_z,
                    input ready);
    modport sink (input valid, vec_x, vec_y, vec_z, angle_x, angle_y, angle_z,
                  output ready);
endinterface

// ===== hw/rtl/exvr_out_if.sv =====
// Output channel: rotated vector word with valid/ready.
`timescale 1ns / 1ps
interface exvr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;

    modport source (output valid, out_x, out_y, out_z, input ready);
    modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

// ===== hw/rtl/exvr_angle.sv =====
// Angle front end: modulo-360 reduction and binary-angle folding, three stages.
`timescale 1ns / 1ps
module exvr_angle (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    output logic                 o_rdy,
    input  exvr_pkg::t_vec       i_vec,
    input  logic [2:0][31:0]     i_ang,
    output logic                 o_vld,
    input  logic                 i_rdy,
    output exvr_pkg::t_crd       o_data
);
    typedef struct packed {
        logic [5:0]  m;
        logic [18:0] l;
        logic [38:0] pl;
    } t_a1;

    typedef struct packed {
        logic [5:0]  m;
        logic [13:0] ql;
        logic [38:0] py;
    } t_a2;

    logic [2:0]     r_vld;
    logic [2:0]     w_en;
    exvr_pkg::t_vec r_vec1;
    exvr_pkg::t_vec r_vec2;
    t_a1 [2:0]      r_s1;
    t_a1 [2:0]      n_s1;
    t_a2 [2:0]      r_s2;
    t_a2 [2:0]      n_s2;
    exvr_pkg::t_crd r_s3;
    exvr_pkg::t_crd n_s3;

    function automatic logic [5:0] f_mod45(input logic [12:0] h);
        logic [13:0] u;
        u = {h[12], h} + 14'd4140;
        for (int j = 7; j >= 0; j--) begin
            if (u >= 14'(45 << j)) begin
                u = u - 14'(45 << j);
            end
        end
        return u[5:0];
    endfunction

    assign w_en[2] = !r_vld[2] || i_rdy;
    assign w_en[1] = !r_vld[1] || w_en[2];
    assign w_en[0] = !r_vld[0] || w_en[1];
    assign o_rdy   = w_en[0];
    assign o_vld   = r_vld[2];
    assign o_data  = r_s3;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_s1[k].m  = f_mod45(i_ang[k][31:19]);
            n_s1[k].l  = i_ang[k][18:0];
            n_s1[k].pl = 39'(i_ang[k][18:0]) * 39'(exvr_pkg::RECIP45);
        end
    end

    always_comb begin
        logic [18:0] rl_full;
        logic [18:0] y;
        for (int k = 0; k < 3; k++) begin
            n_s2[k].m  = r_s1[k].m;
            n_s2[k].ql = r_s1[k].pl[38:25];
            rl_full    = r_s1[k].l - 19'(r_s1[k].pl[38:25]) * 19'd45;
            y          = {rl_full[5:0], 13'b0} + 19'(exvr_pkg::RTAB[r_s1[k].m]) + 19'd22;
            n_s2[k].py = 39'(y) * 39'(exvr_pkg::RECIP45);
        end
    end

    always_comb begin
        logic [31:0] t;
        logic        ng;
        n_s3.vec = r_vec2;
        for (int k = 0; k < 3; k++) begin
            t = exvr_pkg::QTAB[r_s2[k].m] + {5'b0, r_s2[k].ql, 13'b0}
                + {18'b0, r_s2[k].py[38:25]};
            ng = ($signed(t) > 32'sd1073741824) || ($signed(t) < -32'sd1073741824);
            t[31] = t[31] ^ ng;
            n_s3.lane[k].x   = exvr_pkg::GAIN;
            n_s3.lane[k].y   = '0;
            n_s3.lane[k].z   = {{2{t[31]}}, t};
            n_s3.lane[k].neg = ng;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_vld;
            if (w_en[1]) r_vld[1] <= r_vld[0];
            if (w_en[2]) r_vld[2] <= r_vld[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s1   <= n_s1;
            r_vec1 <= i_vec;
        end
        if (w_en[1]) begin
            r_s2   <= n_s2;
            r_vec2 <= r_vec1;
        end
        if (w_en[2]) begin
            r_s3 <= n_s3;
        end
    end
endmodule

// ===== hw/rtl/exvr_cordic.sv =====
// CORDIC chain: one rotation step per stage for three lanes, then sign fix-up.
`timescale 1ns / 1ps
module exvr_cordic (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    output logic            o_rdy,
    input  exvr_pkg::t_crd  i_data,
    output logic            o_vld,
    input  logic            i_rdy,
    output exvr_pkg::t_trig o_data
);
    localparam int NS = exvr_pkg::N_STEPS + 1;

    logic [NS-1:0]  r_vld;
    logic [NS-1:0]  w_en;
    logic [NS-1:0]  w_vin;
    exvr_pkg::t_crd r_stg [NS];
    exvr_pkg::t_crd n_stg [NS];
    exvr_pkg::t_crd w_src [NS];

    for (genvar k = 0; k < NS; k++) begin : g_en
        assign w_en[k] = i_rdy || !(&r_vld[NS-1:k]);
    end

    assign w_vin = {r_vld[NS-2:0], i_vld};
    assign o_rdy = w_en[0];
    assign o_vld = r_vld[NS-1];

    always_comb begin
        w_src[0] = i_data;
        for (int k = 1; k < NS; k++) begin
            w_src[k] = r_stg[k-1];
        end
    end

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            n_stg[k] = w_src[k];
            for (int j = 0; j < 3; j++) begin
                if (k < exvr_pkg::N_STEPS) begin
                    if (!w_src[k].lane[j].z[exvr_pkg::Z_W-1]) begin
                        n_stg[k].lane[j].x = w_src[k].lane[j].x - (w_src[k].lane[j].y >>> k);
                        n_stg[k].lane[j].y = w_src[k].lane[j].y + (w_src[k].lane[j].x >>> k);
                        n_stg[k].lane[j].z = w_src[k].lane[j].z
                                             - $signed({2'b0, exvr_pkg::ATAN_TURN[k]});
                    end else begin
                        n_stg[k].lane[j].x = w_src[k].lane[j].x + (w_src[k].lane[j].y >>> k);
                        n_stg[k].lane[j].y = w_src[k].lane[j].y - (w_src[k].lane[j].x >>> k);
                        n_stg[k].lane[j].z = w_src[k].lane[j].z
                                             + $signed({2'b0, exvr_pkg::ATAN_TURN[k]});
                    end
                end else if (w_src[k].lane[j].neg) begin
                    n_stg[k].lane[j].x = -w_src[k].lane[j].x;
                    n_stg[k].lane[j].y = -w_src[k].lane[j].y;
                end
            end
        end
    end

    always_comb begin
        o_data.vec = r_stg[NS-1].vec;
        for (int j = 0; j < 3; j++) begin
            o_data.sc[j].c = r_stg[NS-1].lane[j].x[31:0];
            o_data.sc[j].s = r_stg[NS-1].lane[j].y[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_en[k]) r_vld[k] <= w_vin[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (w_en[k]) r_stg[k] <= n_stg[k];
        end
    end
endmodule

// ===== hw/rtl/exvr_rotate.sv =====
// Rotation back end: X, Y, Z rotations as multiply and round/sum stage pairs.
`timescale 1ns / 1ps
module exvr_rotate (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    output logic            o_rdy,
    input  exvr_pkg::t_trig i_data,
    output logic            o_vld,
    input  logic            i_rdy,
    output exvr_pkg::t_vec  o_data
);
    typedef struct packed {
        exvr_pkg::t_val  vx;
        exvr_pkg::t_word cy, sy, cz, sz;
        exvr_pkg::t_prod p0, p1, p2, p3;
    } t_r1;

    typedef struct packed {
        exvr_pkg::t_val  vx, mvx, ny, nz;
        exvr_pkg::t_word cy, sy, cz, sz;
    } t_r2;

    typedef struct packed {
        exvr_pkg::t_prod q0, q1, q2, q3;
        exvr_pkg::t_val  ny;
        exvr_pkg::t_word cz, sz;
    } t_r3;

    typedef struct packed {
        exvr_pkg::t_val  nx, nz, ny;
        exvr_pkg::t_word cz, sz;
    } t_r4;

    typedef struct packed {
        exvr_pkg::t_prod s0, s1, s2, s3;
        exvr_pkg::t_val  nz;
    } t_r5;

    logic [5:0]     r_vld;
    logic [5:0]     w_en;
    t_r1            r_s1, n_s1;
    t_r2            r_s2, n_s2;
    t_r3            r_s3, n_s3;
    t_r4            r_s4, n_s4;
    t_r5            r_s5, n_s5;
    exvr_pkg::t_vec r_s6, n_s6;

    for (genvar k = 0; k < 6; k++) begin : g_en
        assign w_en[k] = i_rdy || !(&r_vld[5:k]);
    end

    assign o_rdy  = w_en[0];
    assign o_vld  = r_vld[5];
    assign o_data = r_s6;

    always_comb begin
        n_s1.vx = exvr_pkg::V_W'(i_data.vec.x);
        n_s1.cy = i_data.sc[1].c;
        n_s1.sy = i_data.sc[1].s;
        n_s1.cz = i_data.sc[2].c;
        n_s1.sz = i_data.sc[2].s;
        n_s1.p0 = i_data.vec.y * i_data.sc[0].c;
        n_s1.p1 = i_data.vec.z * i_data.sc[0].s;
        n_s1.p2 = i_data.vec.y * i_data.sc[0].s;
        n_s1.p3 = i_data.vec.z * i_data.sc[0].c;
    end

    always_comb begin
        n_s2.vx  = r_s1.vx;
        n_s2.mvx = -r_s1.vx;
        n_s2.ny  = exvr_pkg::f_rnd(r_s1.p0) - exvr_pkg::f_rnd(r_s1.p1);
        n_s2.nz  = exvr_pkg::f_rnd(r_s1.p2) + exvr_pkg::f_rnd(r_s1.p3);
        n_s2.cy  = r_s1.cy;
        n_s2.sy  = r_s1.sy;
        n_s2.cz  = r_s1.cz;
        n_s2.sz  = r_s1.sz;
    end

    always_comb begin
        n_s3.q0 = r_s2.vx * r_s2.cy;
        n_s3.q1 = r_s2.nz * r_s2.sy;
        n_s3.q2 = r_s2.mvx * r_s2.sy;
        n_s3.q3 = r_s2.nz * r_s2.cy;
        n_s3.ny = r_s2.ny;
        n_s3.cz = r_s2.cz;
        n_s3.sz = r_s2.sz;
    end

    always_comb begin
        n_s4.nx = exvr_pkg::f_rnd(r_s3.q0) + exvr_pkg::f_rnd(r_s3.q1);
        n_s4.nz = exvr_pkg::f_rnd(r_s3.q2) + exvr_pkg::f_rnd(r_s3.q3);
        n_s4.ny = r_s3.ny;
        n_s4.cz = r_s3.cz;
        n_s4.sz = r_s3.sz;
    end

    always_comb begin
        n_s5.s0 = r_s4.nx * r_s4.cz;
        n_s5.s1 = r_s4.ny * r_s4.sz;
        n_s5.s2 = r_s4.nx * r_s4.sz;
        n_s5.s3 = r_s4.ny * r_s4.cz;
        n_s5.nz = r_s4.nz;
    end

    always_comb begin
        n_s6.x = exvr_pkg::f_sat(exvr_pkg::f_rnd(r_s5.s0) - exvr_pkg::f_rnd(r_s5.s1));
        n_s6.y = exvr_pkg::f_sat(exvr_pkg::f_rnd(r_s5.s2) + exvr_pkg::f_rnd(r_s5.s3));
        n_s6.z = exvr_pkg::f_sat(r_s5.nz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_vld;
            for (int k = 1; k < 6; k++) begin
                if (w_en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) r_s1 <= n_s1;
        if (w_en[1]) r_s2 <= n_s2;
        if (w_en[2]) r_s3 <= n_s3;
        if (w_en[3]) r_s4 <= n_s4;
        if (w_en[4]) r_s5 <= n_s5;
        if (w_en[5]) r_s6 <= n_s6;
    end
endmodule

// ===== hw/rtl/euler_xyz_vector_rotation_core.sv =====
// Euler XYZ rotation core: rotates a Q16.16 vector about X, then Y, then Z.
//
// Input channel i_in carries one word per item: vec_x/y/z and angle_x/y/z,
// all signed Q16.16, angles in degrees (any value, reduced modulo 360).
// Output channel o_out carries out_x/y/z, signed Q16.16, saturated.
// A word moves when valid and ready are both high at a rising clock edge.
//
// Throughput: one word per cycle while the receiver does not stall. From input
// acceptance to output valid a word passes three reduction stages,
// one stage per CORDIC step plus a sign stage, and six rotate stages.
//
// Every stage holds its own valid bit; a stalled receiver stops only the
// stages that are full, so bubbles close up and i_in.ready stays high while
// any stage is empty. No word is lost or repeated across a stall.
// Reset (i_rst_n low, synchronous) clears all valid bits; the block keeps no
// other state and needs no warm-up.
`timescale 1ns / 1ps
module euler_xyz_vector_rotation_core (
    input logic        i_clk,
    input logic        i_rst_n,
    exvr_in_if.sink    i_in,
    exvr_out_if.source o_out
);
    exvr_pkg::t_vec   w_vec;
    logic [2:0][31:0] w_ang;
    logic             w_a_vld, w_a_rdy;
    exvr_pkg::t_crd   w_a_data;
    logic             w_c_vld, w_c_rdy;
    exvr_pkg::t_trig  w_c_data;
    exvr_pkg::t_vec   w_res;

    always_comb begin
        w_vec.x = i_in.vec_x;
        w_vec.y = i_in.vec_y;
        w_vec.z = i_in.vec_z;
    end

    assign w_ang = {i_in.angle_z, i_in.angle_y, i_in.angle_x};

    exvr_angle u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_in.valid),
        .o_rdy   (i_in.ready),
        .i_vec   (w_vec),
        .i_ang   (w_ang),
        .o_vld   (w_a_vld),
        .i_rdy   (w_a_rdy),
        .o_data  (w_a_data)
    );

    exvr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_a_vld),
        .o_rdy   (w_a_rdy),
        .i_data  (w_a_data),
        .o_vld   (w_c_vld),
        .i_rdy   (w_c_rdy),
        .o_data  (w_c_data)
    );

    exvr_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_c_vld),
        .o_rdy   (w_c_rdy),
        .i_data  (w_c_data),
        .o_vld   (o_out.valid),
        .i_rdy   (o_out.ready),
        .o_data  (w_res)
    );

    assign o_out.out_x = w_res.x;
    assign o_out.out_y = w_res.y;
    assign o_out.out_z = w_res.z;
endmodule

// ===== hw/rtl/exvr_checker.sv =====
// Port checker for the rotation core, bound to the top level.
`timescale 1ns / 1ps
`include "euler_xyz_vector_rotation_core_defines.svh"
module exvr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_x,
    input logic [31:0] i_out_y,
    input logic [31:0] i_out_z
);
    `EXVR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_x) && $stable(i_out_y) && $stable(i_out_z), "output word changed under stall")
    `EXVR_ASSERT_IMP(a_flow_ready, i_clk, i_rst_n, i_out_ready, i_in_ready, "input blocked while receiver ready")
    `EXVR_ASSERT_IMP(a_empty_ready, i_clk, i_rst_n, !i_out_valid, i_in_ready, "input blocked with output empty")
    `EXVR_ASSERT_IMP(a_stall_full, i_clk, i_rst_n, i_in_valid && !i_in_ready, i_out_valid && !i_out_ready, "input stalled without output stall")
endmodule

bind euler_xyz_vector_rotation_core exvr_checker u_exvr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_x     (o_out.out_x),
    .i_out_y     (o_out.out_y),
    .i_out_z     (o_out.out_z)
);
